### hdl/pdss_pkg.sv
// Shared constants and types for the path dot-segment stripper.
package pdss_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  // most results one input byte can cause: two released dots and the byte
  localparam int unsigned BURST_MAX = 3;

  typedef logic [1:0] burst_cnt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
  } res_t;

endpackage

### hdl/pdss_step.sv
// Per-byte decode: component state and the burst of results for one input byte.
module pdss_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output pdss_pkg::burst_cnt_t burst_n,
  output pdss_pkg::res_t      burst [pdss_pkg::BURST_MAX]
);

  logic [1:0] held_dots;
  logic       in_plain_name;
  logic       last_out_slash;
  logic [1:0] held_dots_next;
  logic       in_plain_name_next;
  logic       last_out_slash_next;

  pdss_pkg::burst_cnt_t n;
  pdss_pkg::res_t       r [pdss_pkg::BURST_MAX];

  always_comb begin
    n                   = '0;
    held_dots_next      = held_dots;
    in_plain_name_next  = in_plain_name;
    last_out_slash_next = last_out_slash;
    for (int i = 0; i < pdss_pkg::BURST_MAX; i++) begin
      r[i] = '{data: pdss_pkg::CH_DOT, has: 1'b1, fin: 1'b0};
    end

    if (in_byte == pdss_pkg::CH_DQ || in_byte == pdss_pkg::CH_SQ) begin
      // drop quotes; state untouched
    end else if (in_byte == pdss_pkg::CH_SLASH) begin
      if (in_plain_name || (held_dots == 2'd0 && !last_out_slash)) begin
        r[0].data           = pdss_pkg::CH_SLASH;
        n                   = 2'd1;
        last_out_slash_next = 1'b1;
      end
      // a held "." or ".." is dropped with this slash
      held_dots_next     = 2'd0;
      in_plain_name_next = 1'b0;
    end else if (in_byte == pdss_pkg::CH_DOT) begin
      if (in_plain_name) begin
        n                   = 2'd1;
        last_out_slash_next = 1'b0;
      end else if (held_dots != 2'd2) begin
        held_dots_next = held_dots + 2'd1;
      end else begin
        n                   = 2'd3;
        last_out_slash_next = 1'b0;
        held_dots_next      = 2'd0;
        in_plain_name_next  = 1'b1;
      end
    end else begin
      if (in_plain_name) begin
        r[0].data = in_byte;
        n         = 2'd1;
      end else begin
        case (held_dots)
          2'd0: begin
            r[0].data = in_byte;
            n         = 2'd1;
          end
          2'd1: begin
            r[1].data = in_byte;
            n         = 2'd2;
          end
          default: begin
            r[2].data = in_byte;
            n         = 2'd3;
          end
        endcase
      end
      held_dots_next      = 2'd0;
      in_plain_name_next  = 1'b1;
      last_out_slash_next = 1'b0;
    end

    if (in_last) begin
      case (n)
        2'd0: begin
          r[0] = '{data: 8'h00, has: 1'b0, fin: 1'b1};
          n    = 2'd1;
        end
        2'd1:    r[0].fin = 1'b1;
        2'd2:    r[1].fin = 1'b1;
        default: r[2].fin = 1'b1;
      endcase
      held_dots_next      = 2'd0;
      in_plain_name_next  = 1'b0;
      last_out_slash_next = 1'b0;
    end
  end

  assign burst_n = n;
  assign burst   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_dots      <= 2'd0;
      in_plain_name  <= 1'b0;
      last_out_slash <= 1'b0;
    end else if (load) begin
      held_dots      <= held_dots_next;
      in_plain_name  <= in_plain_name_next;
      last_out_slash <= last_out_slash_next;
    end
  end

`ifndef SYNTH
  a_held_range: assert property (@(posedge clk) disable iff (rst) held_dots != 2'd3)
    else $error("held dot count out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && in_last |=> held_dots == 2'd0 && !in_plain_name && !last_out_slash)
    else $error("state not cleared after final byte");
  a_plain_no_held: assert property (@(posedge clk) disable iff (rst)
    in_plain_name |-> held_dots == 2'd0)
    else $error("dots held inside a plain name");
`endif

endmodule

### hdl/pdss_outq.sv
// Burst buffer and output register that serialize results one per cycle unless out_stall holds the output.
module pdss_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pdss_pkg::burst_cnt_t burst_n,
  input  pdss_pkg::res_t       burst [pdss_pkg::BURST_MAX],
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pdss_pkg::res_t       out_res
);

  pdss_pkg::burst_cnt_t cnt;
  pdss_pkg::res_t       ent [pdss_pkg::BURST_MAX];
  logic                 out_free;
  logic                 pop;

  assign out_free = !out_valid || !out_stall;
  assign pop      = out_free && (cnt != 2'd0);
  assign room     = (cnt == 2'd0) || (cnt == 2'd1 && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= burst_n;
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold on stall, advance on pop, replace on load
  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= ent[0];
    end
    if (load) begin
      ent <= burst;
    end else if (pop) begin
      ent[0] <= ent[1];
      ent[1] <= ent[2];
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3 || !load)
    else $error("burst loaded over pending results");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> cnt == $past(burst_n))
    else $error("burst count does not match loaded burst");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped result not presented");
`endif

endmodule

### hdl/path_dot_segment_stripper.sv
// Top level of the path dot-segment stripper: byte stream in, sanitized path out.
//
// Takes one path byte per transfer (in_last on the final byte) and returns the
// sanitized path one result per transfer. Quotes are dropped, runs of slashes
// collapse to one, and components that are exactly "." or ".." vanish along
// with their trailing slash; up to two leading dots are held until the
// component's kind is known. A byte may cause zero to three results (released
// dots plus the byte itself); a final byte that causes nothing yields one bare
// end marker with has_byte low and out_last high. An input byte is accepted
// every cycle while out_stall is low, as long as each byte causes at most one
// result; a byte with several results holds off the next one while the output
// port moves them, one per cycle when not stalled, through a three-entry burst
// buffer and then the output register. in_stall follows out_stall in the same
// cycle when the burst buffer is about to empty.
module path_dot_segment_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);

  logic                 room;
  logic                 load;
  pdss_pkg::burst_cnt_t burst_n;
  pdss_pkg::res_t       burst [pdss_pkg::BURST_MAX];
  pdss_pkg::res_t       out_res;

  // take a new byte only when its whole burst fits behind what is pending
  assign in_stall = !room;
  assign load     = in_valid && room;

  // decode the byte against the current component state
  pdss_step u_step (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .in_byte (in_byte),
    .in_last (in_last),
    .burst_n (burst_n),
    .burst   (burst)
  );

  // hold the burst and drain it one result per output transfer
  pdss_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst_n   (burst_n),
    .burst     (burst),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte = out_res.data;
  assign has_byte = out_res.has;
  assign out_last = out_res.fin;

endmodule
